// ----- rtl/pcf_pkg.sv -----
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types, codes and the CRC-32 byte step for the chunk framer.
// ----------------------------------------------------------------------------
`default_nettype none

package pcf_pkg;

    localparam int unsigned LEN_W  = 31;
    localparam int unsigned TYPE_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 32;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned STEP_W = 4;

    localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    // item kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_CHUNK  = 2'd1;
    localparam logic [ST_W-1:0] ST_ABANDONED = 2'd2;

    // sequencer step groups, upper two bits of the step number
    localparam logic [1:0] GRP_LEN     = 2'd0;
    localparam logic [1:0] GRP_TYPE    = 2'd1;
    localparam logic [1:0] GRP_PAYLOAD = 2'd2;
    localparam logic [1:0] GRP_CRC     = 2'd3;

    // first step of each group, lower bits give the byte index (msb first)
    localparam logic [STEP_W-1:0] STEP_LEN0    = {GRP_LEN, 2'd0};
    localparam logic [STEP_W-1:0] STEP_PAYLOAD = {GRP_PAYLOAD, 2'd0};
    localparam logic [STEP_W-1:0] STEP_CRC0    = {GRP_CRC, 2'd0};
    localparam logic [1:0]        IDX_LAST     = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [LEN_W-1:0]  chunk_length;
        logic [TYPE_W-1:0] chunk_type;
        logic [BYTE_W-1:0] payload_byte;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              end_of_chunk;
        logic [ST_W-1:0]   status;
    } result_t;

    // one byte of a 32-bit word, index 0 is the most significant byte
    function automatic logic [BYTE_W-1:0] pick_byte(input logic [31:0] w,
                                                    input logic [1:0]  idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    // reflected crc-32 update over one byte
    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0]  crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pcf_item_if.sv -----
// ----------------------------------------------------------------------------
// pcf_item_if
// Input channel of the chunk framer: chunk starts and payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcf_item_if;

    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [pcf_pkg::LEN_W-1:0]   chunk_length;
    logic [pcf_pkg::TYPE_W-1:0]  chunk_type;
    logic [pcf_pkg::BYTE_W-1:0]  payload_byte;

    modport source (
        output valid, kind, chunk_length, chunk_type, payload_byte,
        input  ready
    );

    modport sink (
        input  valid, kind, chunk_length, chunk_type, payload_byte,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/pcf_result_if.sv -----
// ----------------------------------------------------------------------------
// pcf_result_if
// Output channel of the chunk framer: one byte of the chunk stream each.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcf_result_if;

    logic                        valid;
    logic                        ready;
    logic [pcf_pkg::BYTE_W-1:0]  out_byte;
    logic                        end_of_chunk;
    logic [pcf_pkg::ST_W-1:0]    status;

    modport source (
        output valid, out_byte, end_of_chunk, status,
        input  ready
    );

    modport sink (
        input  valid, out_byte, end_of_chunk, status,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/png_chunk_framer_crc32.sv -----
// ----------------------------------------------------------------------------
// png_chunk_framer_crc32
// Frames png chunks as a byte stream with a reflected crc-32 trailer.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                            bytes/item
//  items     in    kind, chunk_length, chunk_type, payload_byte       -
//  results   out   out_byte, end_of_chunk, status                     1 to 12
//
//  one result byte leaves the sequencer per cycle while the output register
//  can load; an item has 8 or 12 result bytes for a start, 1 or 5 for a
//  payload byte, so without output stalls payload streams at one byte per cycle.
//  the output register port sets the rate; a stalled output freezes the
//  sequencer, and the input register then holds its item and stalls the input
//  until the last byte of that item moves on.
//  reset clears the chunk state (crc all ones, nothing open) at once.
// ----------------------------------------------------------------------------
`default_nettype none

module png_chunk_framer_crc32 (
    input  wire logic      clk,
    input  wire logic      rst_n,
    pcf_item_if.sink       items,
    pcf_result_if.source   results
);

    logic             item_valid;
    pcf_pkg::item_t   item;
    logic             item_done;
    logic             res_valid;
    pcf_pkg::result_t res;
    logic             load;

    // input register
    pcf_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .item_done  (item_done),
        .item_valid (item_valid),
        .item       (item)
    );

    // byte sequencer and crc state
    pcf_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .load       (load),
        .res_valid  (res_valid),
        .res        (res),
        .item_done  (item_done)
    );

    // output register
    pcf_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .load       (load),
        .results    (results)
    );

endmodule

`default_nettype wire

// ----- rtl/pcf_in_reg.sv -----
// ----------------------------------------------------------------------------
// pcf_in_reg
// Input register; holds one item until the sequencer has emitted all of it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_in_reg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    pcf_item_if.sink             items,
    input  wire logic            item_done,
    output logic                 item_valid,
    output pcf_pkg::item_t       item
);

    logic           valid_reg;
    logic           valid_next;
    pcf_pkg::item_t item_reg;
    logic           take;

    // free slot, or the held item leaves in this cycle
    assign items.ready = !valid_reg || item_done;
    assign take        = items.valid && items.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (item_done)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind         <= items.kind;
            item_reg.chunk_length <= items.chunk_length;
            item_reg.chunk_type   <= items.chunk_type;
            item_reg.payload_byte <= items.payload_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- rtl/pcf_seq.sv -----
// ----------------------------------------------------------------------------
// pcf_seq
// Byte sequencer: steps through header, payload and crc bytes of the held
// item, one byte per load, and keeps the chunk state.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire pcf_pkg::item_t  item,
    input  wire logic            load,
    output logic                 res_valid,
    output pcf_pkg::result_t     res,
    output logic                 item_done
);

    logic                          busy_reg;
    logic                          busy_next;
    logic [pcf_pkg::STEP_W-1:0]    step_reg;
    logic [pcf_pkg::STEP_W-1:0]    step_next;
    logic [pcf_pkg::CRC_W-1:0]     crc_reg;
    logic [pcf_pkg::CRC_W-1:0]     crc_next;
    logic [pcf_pkg::LEN_W-1:0]     left_reg;
    logic [pcf_pkg::LEN_W-1:0]     left_next;
    logic                          open_reg;
    logic                          open_next;
    logic [pcf_pkg::ST_W-1:0]      st_reg;

    logic [pcf_pkg::STEP_W-1:0]    cur_step;
    logic [1:0]                    idx;
    logic [pcf_pkg::ST_W-1:0]      st_cur;
    logic [pcf_pkg::CRC_W-1:0]     crc_out;
    logic                          last;
    logic                          fire;
    logic [pcf_pkg::BYTE_W-1:0]    byte_cur;
    logic                          eoc_cur;

    // current step: a new item starts at its first step
    always_comb
    begin
        if (busy_reg)
        begin
            cur_step = step_reg;
        end
        else if (item.kind == pcf_pkg::KIND_PAYLOAD)
        begin
            cur_step = pcf_pkg::STEP_PAYLOAD;
        end
        else
        begin
            cur_step = pcf_pkg::STEP_LEN0;
        end
    end

    assign idx     = cur_step[1:0];
    assign crc_out = crc_reg ^ pcf_pkg::CRC_ALL_ONES;

    // status is fixed on the first step of an item and held after that
    always_comb
    begin
        if (busy_reg)
        begin
            st_cur = st_reg;
        end
        else if (item.kind == pcf_pkg::KIND_START)
        begin
            st_cur = open_reg ? pcf_pkg::ST_ABANDONED : pcf_pkg::ST_OK;
        end
        else
        begin
            st_cur = open_reg ? pcf_pkg::ST_OK : pcf_pkg::ST_NO_CHUNK;
        end
    end

    // byte selection and chunk state update per step
    always_comb
    begin
        byte_cur  = '0;
        eoc_cur   = 1'b0;
        last      = 1'b0;
        step_next = cur_step + pcf_pkg::STEP_W'(1);
        crc_next  = crc_reg;
        left_next = left_reg;
        open_next = open_reg;
        unique case (cur_step[3:2])
            pcf_pkg::GRP_LEN:
            begin
                byte_cur = pcf_pkg::pick_byte({1'b0, item.chunk_length}, idx);
                if (idx == 2'd0)
                begin
                    crc_next  = pcf_pkg::CRC_ALL_ONES;
                    left_next = item.chunk_length;
                    open_next = 1'b1;
                end
            end
            pcf_pkg::GRP_TYPE:
            begin
                byte_cur = pcf_pkg::pick_byte(item.chunk_type, idx);
                crc_next = pcf_pkg::crc32_byte(crc_reg, byte_cur);
                if (idx == pcf_pkg::IDX_LAST)
                begin
                    if (left_reg == '0)
                    begin
                        step_next = pcf_pkg::STEP_CRC0;
                    end
                    else
                    begin
                        last = 1'b1;
                    end
                end
            end
            pcf_pkg::GRP_PAYLOAD:
            begin
                if (!open_reg)
                begin
                    eoc_cur = 1'b1;
                    last    = 1'b1;
                end
                else
                begin
                    byte_cur  = item.payload_byte;
                    crc_next  = pcf_pkg::crc32_byte(crc_reg, item.payload_byte);
                    left_next = left_reg - pcf_pkg::LEN_W'(1);
                    if (left_reg == pcf_pkg::LEN_W'(1))
                    begin
                        step_next = pcf_pkg::STEP_CRC0;
                    end
                    else
                    begin
                        last = 1'b1;
                    end
                end
            end
            pcf_pkg::GRP_CRC:
            begin
                byte_cur = pcf_pkg::pick_byte(crc_out, idx);
                if (idx == pcf_pkg::IDX_LAST)
                begin
                    eoc_cur   = 1'b1;
                    last      = 1'b1;
                    crc_next  = pcf_pkg::CRC_ALL_ONES;
                    left_next = '0;
                    open_next = 1'b0;
                end
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
    end

    assign fire      = item_valid && load;
    assign busy_next = !last;
    assign item_done = fire && last;

    // chunk state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= pcf_pkg::STEP_LEN0;
            crc_reg  <= pcf_pkg::CRC_ALL_ONES;
            left_reg <= '0;
            open_reg <= 1'b0;
            st_reg   <= pcf_pkg::ST_OK;
        end
        else if (fire)
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            crc_reg  <= crc_next;
            left_reg <= left_next;
            open_reg <= open_next;
            st_reg   <= st_cur;
        end
    end

    assign res_valid        = item_valid;
    assign res.out_byte     = byte_cur;
    assign res.end_of_chunk = eoc_cur;
    assign res.status       = st_cur;

endmodule

`default_nettype wire

// ----- rtl/pcf_out_reg.sv -----
// ----------------------------------------------------------------------------
// pcf_out_reg
// Output register; holds one result byte until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              res_valid,
    input  wire pcf_pkg::result_t  res,
    output logic                   load,
    pcf_result_if.source           results
);

    logic             valid_reg;
    pcf_pkg::result_t res_reg;

    // empty, or the held byte leaves in this cycle
    assign load = !valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= res_valid;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign results.valid        = valid_reg;
    assign results.out_byte     = res_reg.out_byte;
    assign results.end_of_chunk = res_reg.end_of_chunk;
    assign results.status       = res_reg.status;

endmodule

`default_nettype wire

// ----- verif/png_chunk_stream_checker.sv -----
// ----------------------------------------------------------------------------
// png_chunk_stream_checker
// Watches both channels of the chunk framer, keeps its own copy of the
// chunk state and running crc-32, and compares every byte that leaves the
// block with the byte it should be, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module png_chunk_stream_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    pcf_item_if       items,
    pcf_result_if     results,
    output int        mismatches,
    output int        bytes_owed
);

    // shadow of the chunk state
    logic [pcf_pkg::CRC_W-1:0] crc_acc   = pcf_pkg::CRC_ALL_ONES;
    logic [pcf_pkg::LEN_W-1:0] left_cnt  = '0;
    logic                      open_flag = 1'b0;

    // bytes the block still owes, oldest first
    pcf_pkg::result_t owed_bytes[$];

    int err_total  = 0;
    int seen_bytes = 0;

    assign mismatches = err_total;

    // reflected crc-32, one byte, lsb first
    function automatic logic [pcf_pkg::CRC_W-1:0] crc32_update(
        input logic [pcf_pkg::CRC_W-1:0]  crc,
        input logic [pcf_pkg::BYTE_W-1:0] b
    );
        logic [pcf_pkg::CRC_W-1:0] c;
        c = crc ^ {24'd0, b};
        repeat (8)
        begin
            if (c[0])
                c = (c >> 1) ^ pcf_pkg::CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        err_total++;
        $display("%0t: chunk stream mismatch at byte %0d: %s got 0x%0h want 0x%0h",
                 $time, seen_bytes, what, got, want);
    endtask

    task automatic queue_byte(input logic [pcf_pkg::BYTE_W-1:0] b, input logic eoc,
                              input logic [pcf_pkg::ST_W-1:0] st);
        pcf_pkg::result_t r;
        r.out_byte     = b;
        r.end_of_chunk = eoc;
        r.status       = st;
        owed_bytes = {owed_bytes, r};
    endtask

    // crc trailer, big-endian, last byte marked; closes the chunk
    task automatic queue_crc_trailer(input logic [pcf_pkg::ST_W-1:0] st);
        logic [pcf_pkg::CRC_W-1:0] v;
        v = crc_acc ^ pcf_pkg::CRC_ALL_ONES;
        queue_byte(v[31:24], 1'b0, st);
        queue_byte(v[23:16], 1'b0, st);
        queue_byte(v[15:8],  1'b0, st);
        queue_byte(v[7:0],   1'b1, st);
        crc_acc   = pcf_pkg::CRC_ALL_ONES;
        left_cnt  = '0;
        open_flag = 1'b0;
    endtask

    // bytes that one accepted transaction must produce
    task automatic predict_framing(input pcf_pkg::item_t it);
        logic [31:0]              word;
        logic [pcf_pkg::ST_W-1:0] st;
        if (it.kind == pcf_pkg::KIND_START)
        begin
            st   = open_flag ? pcf_pkg::ST_ABANDONED : pcf_pkg::ST_OK;
            word = {1'b0, it.chunk_length};
            for (int k = 3; k >= 0; k--)
                queue_byte(word[8*k +: 8], 1'b0, st);
            crc_acc = pcf_pkg::CRC_ALL_ONES;
            for (int k = 3; k >= 0; k--)
            begin
                queue_byte(it.chunk_type[8*k +: 8], 1'b0, st);
                crc_acc = crc32_update(crc_acc, it.chunk_type[8*k +: 8]);
            end
            left_cnt  = it.chunk_length;
            open_flag = 1'b1;
            if (it.chunk_length == '0)
                queue_crc_trailer(st);
        end
        else if (!open_flag)
        begin
            // stray byte: dropped, flagged, state untouched
            queue_byte(8'h00, 1'b1, pcf_pkg::ST_NO_CHUNK);
        end
        else
        begin
            queue_byte(it.payload_byte, 1'b0, pcf_pkg::ST_OK);
            crc_acc  = crc32_update(crc_acc, it.payload_byte);
            left_cnt = left_cnt - pcf_pkg::LEN_W'(1);
            if (left_cnt == '0)
                queue_crc_trailer(pcf_pkg::ST_OK);
        end
    endtask

    // observe, predict, compare
    always @(posedge clk)
    begin
        pcf_pkg::item_t   it;
        pcf_pkg::result_t got;
        pcf_pkg::result_t want;
        if (!rst_n)
        begin
            crc_acc   = pcf_pkg::CRC_ALL_ONES;
            left_cnt  = '0;
            open_flag = 1'b0;
            owed_bytes.delete();
            bytes_owed <= 0;
        end
        else
        begin
            if (items.valid && items.ready)
            begin
                it.kind         = items.kind;
                it.chunk_length = items.chunk_length;
                it.chunk_type   = items.chunk_type;
                it.payload_byte = items.payload_byte;
                predict_framing(it);
            end
            if (results.valid && results.ready)
            begin
                got.out_byte     = results.out_byte;
                got.end_of_chunk = results.end_of_chunk;
                got.status       = results.status;
                if (owed_bytes.size() == 0)
                    report("byte with nothing pending", 32'(got.out_byte), 32'd0);
                else
                begin
                    want = owed_bytes.pop_front();
                    if (got.out_byte !== want.out_byte)
                        report("out_byte", 32'(got.out_byte), 32'(want.out_byte));
                    if (got.end_of_chunk !== want.end_of_chunk)
                        report("end_of_chunk", 32'(got.end_of_chunk),
                               32'(want.end_of_chunk));
                    if (got.status !== want.status)
                        report("status", 32'(got.status), 32'(want.status));
                end
                seen_bytes++;
            end
            bytes_owed <= owed_bytes.size();
        end
    end

endmodule

`default_nettype wire

// ----- verif/png_chunk_framer_crc32_tb.sv -----
// ----------------------------------------------------------------------------
// png_chunk_framer_crc32_tb
// Drives chunk starts and payload bytes into the framer: a directed pass
// over empty, short, cut-short and abandoned chunks and stray bytes, then
// random chunk traffic under several idle and stall mixes, with one long
// output hold-off. A side checker predicts and compares the byte stream.
// ----------------------------------------------------------------------------
`default_nettype none

module png_chunk_framer_crc32_tb;

    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 40;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic hold_req  = 1'b0;
    int   stall_pct = 0;
    int   idle_pct  = 0;
    int   sent      = 0;
    int   quiet_cycles = 0;
    int   mismatches;
    int   bytes_owed;

    pcf_item_if   items();
    pcf_result_if results();

    png_chunk_framer_crc32 i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    png_chunk_stream_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .results    (results),
        .mismatches (mismatches),
        .bytes_owed (bytes_owed)
    );

    // clock
    always
    begin
        #2;
        clk = ~clk;
    end

    // output side: random stalls plus one long hold-off
    initial
    begin : receiver
        int   hold_left;
        logic hold_taken;
        hold_left     = 0;
        hold_taken    = 1'b0;
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (!rst_n)
                results.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                results.ready <= 1'b0;
            end
            else
                results.ready <= (int'($urandom_range(99)) >= stall_pct);
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (items.valid && items.ready) || (results.valid && results.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic pcf_pkg::item_t start_item(
        input logic [pcf_pkg::LEN_W-1:0]  len,
        input logic [pcf_pkg::TYPE_W-1:0] typ
    );
        pcf_pkg::item_t it;
        it.kind         = pcf_pkg::KIND_START;
        it.chunk_length = len;
        it.chunk_type   = typ;
        it.payload_byte = pcf_pkg::BYTE_W'($urandom());
        return it;
    endfunction

    function automatic pcf_pkg::item_t payload_item(input logic [pcf_pkg::BYTE_W-1:0] b);
        pcf_pkg::item_t it;
        it.kind         = pcf_pkg::KIND_PAYLOAD;
        it.chunk_length = pcf_pkg::LEN_W'($urandom());
        it.chunk_type   = pcf_pkg::TYPE_W'($urandom());
        it.payload_byte = b;
        return it;
    endfunction

    // one transaction on the input side, with random idle cycles in front
    task automatic send_item(input pcf_pkg::item_t it);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
        end
        items.valid        <= 1'b1;
        items.kind         <= it.kind;
        items.chunk_length <= it.chunk_length;
        items.chunk_type   <= it.chunk_type;
        items.payload_byte <= it.payload_byte;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_chunk(input logic [pcf_pkg::LEN_W-1:0] len, input int n_bytes);
        send_item(start_item(len, pcf_pkg::TYPE_W'($urandom())));
        repeat (n_bytes)
            send_item(payload_item(pcf_pkg::BYTE_W'($urandom())));
    endtask

    // mostly complete chunks, some cut short, some stray bytes
    task automatic random_traffic(input int stop_at);
        int                        pick;
        int                        cut;
        logic [pcf_pkg::LEN_W-1:0] len;
        while (sent < stop_at)
        begin
            pick = int'($urandom_range(99));
            if (pick < 70)
            begin
                len = pcf_pkg::LEN_W'($urandom_range(0, 12));
                send_chunk(len, int'(len));
            end
            else if (pick < 80)
            begin
                len = pcf_pkg::LEN_W'($urandom_range(13, 40));
                send_chunk(len, int'(len));
            end
            else if (pick < 92)
            begin
                // cut short, the next start abandons it
                if ($urandom_range(1) == 0)
                begin
                    len = pcf_pkg::LEN_W'($urandom_range(2, 30));
                    cut = int'($urandom_range(0, (len > 9) ? 8 : int'(len) - 1));
                end
                else
                begin
                    len = pcf_pkg::LEN_W'($urandom()) | pcf_pkg::LEN_W'(32'h100);
                    cut = int'($urandom_range(0, 8));
                end
                send_chunk(len, cut);
            end
            else
                repeat ($urandom_range(1, 3))
                    send_item(payload_item(pcf_pkg::BYTE_W'($urandom())));
        end
    endtask

    // stimulus and verdict
    initial
    begin
        items.valid        = 1'b0;
        items.kind         = pcf_pkg::KIND_START;
        items.chunk_length = '0;
        items.chunk_type   = '0;
        items.payload_byte = '0;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stray byte, empty chunks, normal chunk, abandons
        send_item(payload_item(8'hFF));
        send_item(start_item(31'd0, 32'hFFFF_FFFF));
        send_item(start_item(31'd0, 32'h0000_0000));
        send_item(start_item(31'd3, 32'h4944_4154));
        send_item(payload_item(8'h00));
        send_item(payload_item(8'hFF));
        send_item(payload_item(8'hA5));
        send_item(start_item(31'd2, 32'h7445_5874));
        send_item(payload_item(8'h5A));
        send_item(start_item(31'h7FFF_FFFF, 32'h8000_0001));
        send_item(payload_item(8'h81));
        send_item(start_item(31'd1, 32'h7FFF_FFFE));
        send_item(payload_item(8'h01));
        send_item(payload_item(8'h7E));
        send_item(start_item(31'h4000_0000, 32'h4945_4E44));
        send_item(start_item(31'd0, 32'h4945_4E44));
        send_item(payload_item(8'h00));

        // long output hold-off while the input keeps offering
        hold_req <= 1'b1;
        send_chunk(31'd60, 60);

        // no idling
        random_traffic(110);

        // sender mostly idle
        idle_pct = 85;
        random_traffic(150);

        // receiver mostly stalled
        idle_pct = 0;
        stall_pct <= 85;
        random_traffic(190);

        // light idling on both sides
        idle_pct = 7;
        stall_pct <= 7;
        random_traffic(228);

        // drain
        items.valid <= 1'b0;
        stall_pct   <= 0;
        @(posedge clk);
        while (bytes_owed != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (mismatches == 0 && bytes_owed == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
